/* rtl/core/brfi_pkg.sv */
// ----------------------------------------------------------------------------
// brfi_pkg: shared definitions for the byte ring FIFO
// Command codes, byte width and the default capacity of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

package brfi_pkg;

    localparam int CAPACITY_DEF = 255;
    localparam int BYTE_W       = 8;
    localparam int CMD_W        = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_POKE  = 3'd3,
        CMD_SKIP  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/brfi_ram.sv */
// ----------------------------------------------------------------------------
// brfi_ram: byte store of the ring FIFO
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brfi_ram #(
    parameter int DEPTH  = brfi_pkg::CAPACITY_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [brfi_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [brfi_pkg::BYTE_W-1:0] rd_data
);
    import brfi_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/byte_ring_fifo_indexed_unit.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_indexed_unit: byte ring FIFO driven by per-item commands
// Push, pop, peek, poke, skip and clear on a ring of CAPACITY bytes.
// ----------------------------------------------------------------------------
// Usage
// Each input item (cmd, data_in, offset, amount) is taken when in_valid and
// in_ready are both high, and yields exactly one result item (data_out, ok,
// occupancy, space_left) on the output channel, in order.
// The pointers move and the store is written or read at the edge that
// accepts the item; the read byte and the result flags sit in a middle stage
// and pass on to the output register once it is free or being emptied.
// While the receiver keeps out_ready high, one item per cycle is sustained,
// set by the single write and single read port of the store.
// When the receiver stalls, the output register and the middle stage fill
// up and in_ready drops after two items are held; nothing is lost.
// Reset empties the ring (both pointers to zero) and clears both stages.
// The stored bytes are not cleared: only written bytes are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_indexed_unit #(
    parameter int CAPACITY = brfi_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [brfi_pkg::CMD_W-1:0]  cmd,
    input  logic [brfi_pkg::BYTE_W-1:0] data_in,
    input  logic [brfi_pkg::BYTE_W-1:0] offset,
    input  logic [brfi_pkg::BYTE_W-1:0] amount,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [brfi_pkg::BYTE_W-1:0] data_out,
    output logic                        ok,
    output logic [brfi_pkg::BYTE_W-1:0] occupancy,
    output logic [brfi_pkg::BYTE_W-1:0] space_left
);
    import brfi_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int CW    = (PTR_W > BYTE_W) ? PTR_W : BYTE_W;
    localparam int SUM_W = CW + 1;

    typedef struct packed {
        logic              rd_sel;
        logic              ok;
        logic [BYTE_W-1:0] occupancy;
        logic [BYTE_W-1:0] space_left;
    } result_meta_t;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;

    logic             mid_valid_reg;
    result_meta_t     mid_meta_reg, mid_meta_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_out_reg;
    result_meta_t      out_meta_reg;

    logic accept;
    logic mid_adv;

    logic [SUM_W-1:0] slots_w, cap_w, occ_w, occ_after, space_after;
    logic [SUM_W-1:0] off_w, amt_w, off_sum, amt_sum, off_wrap, amt_wrap;
    logic [PTR_W-1:0] head_inc, tail_inc;

    logic              ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]  ram_wr_addr, ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    cmd_t cmd_op;

    assign mid_adv  = mid_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !mid_valid_reg || mid_adv;
    assign accept   = in_valid && in_ready;

    assign slots_w = SUM_W'(SLOTS);
    assign cap_w   = SUM_W'(CAPACITY);
    assign off_w   = SUM_W'(offset);
    assign amt_w   = SUM_W'(amount);

    // Occupancy from the two pointers, allowing for the wrap of the tail.
    assign occ_w = (tail_reg >= head_reg)
                 ? SUM_W'(tail_reg) - SUM_W'(head_reg)
                 : slots_w + SUM_W'(tail_reg) - SUM_W'(head_reg);

    // The offset and amount are only used when below or equal to the
    // occupancy, so one subtraction of the ring size is enough.
    assign off_sum  = SUM_W'(head_reg) + off_w;
    assign amt_sum  = SUM_W'(head_reg) + amt_w;
    assign off_wrap = (off_sum >= slots_w) ? off_sum - slots_w : off_sum;
    assign amt_wrap = (amt_sum >= slots_w) ? amt_sum - slots_w : amt_sum;

    assign head_inc = (SUM_W'(head_reg) == slots_w - SUM_W'(1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (SUM_W'(tail_reg) == slots_w - SUM_W'(1)) ? '0 : tail_reg + 1'b1;

    assign cmd_op = cmd_t'(cmd);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_after   = occ_w;
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        mid_meta_next.rd_sel = 1'b0;
        mid_meta_next.ok     = 1'b0;
        unique case (cmd_op)
            CMD_PUSH:
            begin
                if (occ_w < cap_w)
                begin
                    ram_wr_en        = accept;
                    tail_next        = tail_inc;
                    occ_after        = occ_w + SUM_W'(1);
                    mid_meta_next.ok = 1'b1;
                end
            end
            CMD_POP:
            begin
                if (occ_w != '0)
                begin
                    ram_rd_en            = accept;
                    head_next            = head_inc;
                    occ_after            = occ_w - SUM_W'(1);
                    mid_meta_next.ok     = 1'b1;
                    mid_meta_next.rd_sel = 1'b1;
                end
            end
            CMD_PEEK:
            begin
                if (off_w < occ_w)
                begin
                    ram_rd_en            = accept;
                    ram_rd_addr          = off_wrap[PTR_W-1:0];
                    mid_meta_next.ok     = 1'b1;
                    mid_meta_next.rd_sel = 1'b1;
                end
            end
            CMD_POKE:
            begin
                if (off_w < occ_w)
                begin
                    ram_wr_en        = accept;
                    ram_wr_addr      = off_wrap[PTR_W-1:0];
                    mid_meta_next.ok = 1'b1;
                end
            end
            CMD_SKIP:
            begin
                if (amt_w <= occ_w)
                begin
                    head_next        = amt_wrap[PTR_W-1:0];
                    occ_after        = occ_w - amt_w;
                    mid_meta_next.ok = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                head_next        = '0;
                tail_next        = '0;
                occ_after        = '0;
                mid_meta_next.ok = 1'b1;
            end
            default:
            begin
                // Unused codes leave the ring untouched and report failure.
            end
        endcase
        space_after              = cap_w - occ_after;
        mid_meta_next.occupancy  = occ_after[BYTE_W-1:0];
        mid_meta_next.space_left = space_after[BYTE_W-1:0];
    end

    brfi_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (data_in),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
            end
            mid_valid_reg <= accept || (mid_valid_reg && !mid_adv);
            out_valid_reg <= mid_valid_reg || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_meta_reg <= mid_meta_next;
        end
        if (mid_adv)
        begin
            out_meta_reg <= mid_meta_reg;
            data_out_reg <= mid_meta_reg.rd_sel ? ram_rd_data : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign ok         = out_meta_reg.ok;
    assign occupancy  = out_meta_reg.occupancy;
    assign space_left = out_meta_reg.space_left;

    // Occupancy and free space always add up to the capacity.
    a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (BYTE_W'(occupancy + space_left) == BYTE_W'(CAPACITY)))
        else $error("occupancy and space_left do not add up to the capacity");

    // A failed command never returns a byte.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (data_out == '0))
        else $error("failed command returned a non-zero byte");

    // Both stages held by a stalled receiver must block new items.
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && mid_valid_reg) |-> !in_ready)
        else $error("item accepted while both result stages are held");

    // The pointers never leave the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(head_reg) < slots_w) && (SUM_W'(tail_reg) < slots_w))
        else $error("ring pointer out of range");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: command-driven check of the byte ring FIFO
// Drives push, pop, peek, poke, skip, clear and the unused command codes
// through the valid/ready input channel. A scoreboard class keeps its own
// copy of the ring and the two pointers, works out the reply to every
// accepted item and compares each reply field by field. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import brfi_pkg::*;

    localparam int RING_BYTES  = CAPACITY_DEF;
    localparam int ITEM_TARGET = 900;
    localparam int STALL_LIMIT = 4000;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              ok;
        logic [BYTE_W-1:0] level;
        logic [BYTE_W-1:0] room;
    } ring_reply_t;

    // Shadow of the ring. With 255 usable bytes the store has 256 slots, so
    // 8-bit pointers wrap exactly where the ring does.
    class ring_tracker;
        logic [BYTE_W-1:0] store [256];
        logic [BYTE_W-1:0] rd_ptr;
        logic [BYTE_W-1:0] wr_ptr;
        ring_reply_t       awaited [$];
        int                errors;
        int                taken;
        int                refused;
        int                full_hits;
        int                empty_hits;

        function new();
            rd_ptr     = '0;
            wr_ptr     = '0;
            errors     = 0;
            taken      = 0;
            refused    = 0;
            full_hits  = 0;
            empty_hits = 0;
        endfunction

        function void note_command(logic [CMD_W-1:0] code, logic [BYTE_W-1:0] data,
                                   logic [BYTE_W-1:0] off, logic [BYTE_W-1:0] amt);
            ring_reply_t       r;
            logic [BYTE_W-1:0] level;
            level      = wr_ptr - rd_ptr;
            r.byte_val = '0;
            r.ok       = 1'b0;
            case (code)
                CMD_PUSH:
                begin
                    if (level != BYTE_W'(RING_BYTES))
                    begin
                        store[wr_ptr] = data;
                        wr_ptr        = wr_ptr + 1'b1;
                        r.ok          = 1'b1;
                    end
                    else
                        full_hits++;
                end
                CMD_POP:
                begin
                    if (level != 0)
                    begin
                        r.byte_val = store[rd_ptr];
                        rd_ptr     = rd_ptr + 1'b1;
                        r.ok       = 1'b1;
                    end
                    else
                        empty_hits++;
                end
                CMD_PEEK:
                begin
                    if (off < level)
                    begin
                        r.byte_val = store[BYTE_W'(rd_ptr + off)];
                        r.ok       = 1'b1;
                    end
                end
                CMD_POKE:
                begin
                    if (off < level)
                    begin
                        store[BYTE_W'(rd_ptr + off)] = data;
                        r.ok = 1'b1;
                    end
                end
                CMD_SKIP:
                begin
                    if (amt <= level)
                    begin
                        rd_ptr = rd_ptr + amt;
                        r.ok   = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    rd_ptr = '0;
                    wr_ptr = '0;
                    r.ok   = 1'b1;
                end
                default:
                begin
                end
            endcase
            level   = wr_ptr - rd_ptr;
            r.level = level;
            r.room  = BYTE_W'(RING_BYTES) - level;
            taken++;
            if (!r.ok)
                refused++;
            awaited = {awaited, r};
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(ring_reply_t got);
            ring_reply_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: reply with none outstanding, expected nothing, actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = awaited.pop_front();
                report("data_out", want.byte_val, got.byte_val);
                report("ok", want.ok, got.ok);
                report("occupancy", want.level, got.level);
                report("space_left", want.room, got.room);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_in;
    logic [BYTE_W-1:0] offset;
    logic [BYTE_W-1:0] amount;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] data_out;
    logic              ok;
    logic [BYTE_W-1:0] occupancy;
    logic [BYTE_W-1:0] space_left;

    ring_tracker tracker = new();
    int          est_level;
    int          sent;
    int          fills;
    int          idle_cycles;
    bit          quiet;

    byte_ring_fifo_indexed_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_in    (data_in),
        .offset     (offset),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .ok         (ok),
        .occupancy  (occupancy),
        .space_left (space_left)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Mostly no gap, some short ones, an occasional long one.
    function int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_command(cmd, data_in, offset, amount);
            if (out_valid && out_ready)
                tracker.check_reply(ring_reply_t'({data_out, ok, occupancy, space_left}));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: runs of ready broken by stalls of random length.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            int run;
            int gap;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic issue_command(logic [CMD_W-1:0] code, logic [BYTE_W-1:0] data,
                                 logic [BYTE_W-1:0] off, logic [BYTE_W-1:0] amt);
        int gap;
        in_valid <= 1'b1;
        cmd      <= code;
        data_in  <= data;
        offset   <= off;
        amount   <= amt;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        // Rough fill level, only used to steer the stimulus.
        case (code)
            CMD_PUSH:  if (est_level < RING_BYTES) est_level++;
            CMD_POP:   if (est_level > 0) est_level--;
            CMD_SKIP:  if (amt <= est_level) est_level -= amt;
            CMD_CLEAR: est_level = 0;
            default:
            begin
            end
        endcase
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          burst;
        int unsigned roll;
        int          top;
        logic [CMD_W-1:0]  code;
        logic [BYTE_W-1:0] off;
        logic [BYTE_W-1:0] amt;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_PUSH;
        data_in   <= '0;
        offset    <= '0;
        amount    <= '0;
        est_level = 0;
        sent      = 0;
        fills     = 0;
        quiet     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring, unused codes, then a few bytes to peek, poke and skip over.
        issue_command(CMD_POP, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_PEEK, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_SKIP, 8'h00, 8'd0, 8'd1);
        issue_command(CMD_SKIP, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_SPARE_LO, 8'hFF, 8'd254, 8'd255);
        issue_command(CMD_SPARE_HI, 8'hFF, 8'd254, 8'd255);
        issue_command(CMD_PUSH, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_PUSH, 8'hFF, 8'd0, 8'd0);
        issue_command(CMD_PUSH, 8'hA5, 8'd0, 8'd0);
        issue_command(CMD_PEEK, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_PEEK, 8'h00, 8'd2, 8'd0);
        issue_command(CMD_PEEK, 8'h00, 8'd3, 8'd0);
        issue_command(CMD_PEEK, 8'h00, 8'd254, 8'd0);
        issue_command(CMD_POKE, 8'h5A, 8'd1, 8'd0);
        issue_command(CMD_POKE, 8'hC3, 8'd3, 8'd0);
        issue_command(CMD_PEEK, 8'h00, 8'd1, 8'd0);
        issue_command(CMD_POP, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_SKIP, 8'h00, 8'd0, 8'd5);
        issue_command(CMD_SKIP, 8'h00, 8'd0, 8'd255);
        issue_command(CMD_SKIP, 8'h00, 8'd0, 8'd1);
        issue_command(CMD_POP, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_POP, 8'h00, 8'd0, 8'd0);
        issue_command(CMD_PUSH, 8'h3C, 8'd0, 8'd0);
        issue_command(CMD_CLEAR, 8'h00, 8'd0, 8'd0);
        wait_drained();

        while (sent < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            roll  = $urandom_range(0, 99);
            if (fills == 0 && sent >= 400)
                roll = 0;
            if (roll < 6)
            begin
                // Fill to the brim, work at the last slot, overflow, then drop a run.
                fills++;
                while (est_level < RING_BYTES)
                    issue_command(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
                issue_command(CMD_PEEK, 8'($urandom), 8'd254, 8'($urandom));
                issue_command(CMD_POKE, 8'($urandom), 8'd254, 8'($urandom));
                issue_command(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
                issue_command(CMD_PEEK, 8'($urandom), 8'd254, 8'($urandom));
                issue_command(CMD_SKIP, 8'($urandom), 8'($urandom),
                              8'($urandom_range(0, 255)));
            end
            else if (roll < 14)
            begin
                while (est_level > 0)
                    issue_command(CMD_POP, 8'($urandom), 8'($urandom), 8'($urandom));
                issue_command(CMD_POP, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else if (roll < 19)
                wait_drained();
            else
            begin
                burst = $urandom_range(5, 30);
                repeat (burst)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 35)
                        code = CMD_PUSH;
                    else if (roll < 55)
                        code = CMD_POP;
                    else if (roll < 70)
                        code = CMD_PEEK;
                    else if (roll < 82)
                        code = CMD_POKE;
                    else if (roll < 92)
                        code = CMD_SKIP;
                    else if (roll < 96)
                        code = CMD_CLEAR;
                    else if (roll < 98)
                        code = CMD_SPARE_LO;
                    else
                        code = CMD_SPARE_HI;
                    // Offsets and counts mostly lie up to the fill level, with
                    // one past the end included; the rest span the field.
                    top = (est_level > 254) ? 254 : est_level;
                    if ($urandom_range(0, 9) < 7)
                        off = 8'($urandom_range(0, top));
                    else
                        off = 8'($urandom_range(0, 254));
                    if ($urandom_range(0, 9) < 7)
                        amt = 8'($urandom_range(0, est_level));
                    else
                        amt = 8'($urandom_range(0, 255));
                    issue_command(code, 8'($urandom), off, amt);
                end
            end
        end

        quiet = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d commands, %0d of them refused, across %0d full-ring passes.",
                 tracker.taken, tracker.refused, fills);
        $display("Pushes refused on a full ring: %0d; pops refused on an empty ring: %0d.",
                 tracker.full_hits, tracker.empty_hits);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
